[hw/rtl/mpbm_pkg.sv]
package mpbm_pkg;

  // Input sample port and the bits of it that are used
  localparam int SAMPLE_W    = 12;
  localparam int SAMPLE_BITS = 12;
  localparam int SMP_USE_W   = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;

  // Averaging window, power of two
  localparam int WIN_LOG2 = 10;
  localparam int WINDOW   = 1 << WIN_LOG2;

  // Datapath widths
  localparam int SQ_W     = 2 * SMP_USE_W;
  localparam int SUM_W    = SQ_W + WIN_LOG2;
  localparam int MEAN_W   = 24;
  localparam int MEAN_X_W = (SQ_W > MEAN_W) ? SQ_W : MEAN_W;
  localparam int BAR_W    = 8;

  // Threshold registers
  localparam int LEVELS    = 8;
  localparam int LVL_AW    = 3;
  localparam int THR_W     = 24;
  localparam int CFG_IDX_W = 4;

  // Output queue
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = 2;
  localparam int OQ_CW    = 3;

  typedef logic [THR_W-1:0]  thr_t;
  typedef logic [MEAN_W-1:0] mean_t;
  typedef logic [BAR_W-1:0]  bar_t;

  typedef struct packed {
    bar_t  bar;
    mean_t mean;
  } res_t;

  localparam thr_t THR_RESET [LEVELS] = '{
    thr_t'(5000),  thr_t'(20000), thr_t'(35000), thr_t'(50000),
    thr_t'(65000), thr_t'(80000), thr_t'(95000), thr_t'(110000)
  };

  localparam mean_t MEAN_MAX = '1;

endpackage

[hw/rtl/moving_power_bar_meter_unit.sv]
// Channel  Direction  Handshake               Payload
// in_      input      in_valid / in_stall     in_sample (12b)
// out_     output     out_valid / out_stall   out_bar_pattern (8b), out_mean_power (24b)
// cfg_     input      cfg_we                  cfg_index (4b), cfg_data (24b)
//
// One word in and one word out per cycle, sustained while out_stall is low.
// out_valid rises once a word has passed square + RAM read, sum update and the
// compare into the output queue. A square is written back to the window RAM in
// the cycle after its old entry is read. Sync active-low reset; unwritten
// entries read as zero until the write pointer first wraps. in_stall rises
// only when 4 words are in flight or queued on the output.
module moving_power_bar_meter_unit
  import mpbm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [SAMPLE_W-1:0]  in_sample,

  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [BAR_W-1:0]     out_bar_pattern,
  output logic [MEAN_W-1:0]    out_mean_power,

  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [THR_W-1:0]     cfg_data
);

  // Handshakes
  logic in_acc;
  logic out_acc;

  // Write pointer into the window RAM, and "every entry written" flag
  logic [WIN_LOG2-1:0] ptr_r, ptr_nxt;
  logic                wrapped_r, wrapped_nxt;

  // Stage 1: square and old-entry read in flight
  logic                s1_v_r;
  logic [SQ_W-1:0]     s1_sq_r;
  logic [WIN_LOG2-1:0] s1_ptr_r;
  logic                s1_old_ok_r;
  logic [SQ_W-1:0]     ram_rd;
  logic [SQ_W-1:0]     old_sq;

  // Stage 2: running sum holds the sum for the word in this stage
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic                s2_v_r;

  // Compare
  logic [MEAN_X_W-1:0] mean_x;
  logic [LEVELS-1:0]   exceed;
  res_t                res_nxt;

  // Thresholds
  thr_t thr_r [LEVELS];

  // Output queue and occupancy (words accepted but not yet delivered)
  res_t             oq_r [OQ_DEPTH];
  logic [OQ_AW-1:0] oq_wp_r, oq_rp_r;
  logic [OQ_CW-1:0] oq_cnt_r, oq_cnt_nxt;
  logic [OQ_CW-1:0] busy_r, busy_nxt;

  assign in_stall  = (busy_r >= OQ_CW'(OQ_DEPTH));
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = (oq_cnt_r != '0);
  assign out_acc   = out_valid && !out_stall;

  // ---------------------------------------------------------------
  // Window store: read the oldest entry at accept, overwrite it with
  // the new square in the following cycle.
  // ---------------------------------------------------------------
  mpbm_ram #(
    .WIDTH (SQ_W),
    .DEPTH (WINDOW)
  ) u_win_ram (
    .clk     (clk),
    .wr_en   (s1_v_r),
    .wr_addr (s1_ptr_r),
    .wr_data (s1_sq_r),
    .rd_addr (ptr_r),
    .rd_data (ram_rd)
  );

  always_comb begin
    ptr_nxt     = ptr_r;
    wrapped_nxt = wrapped_r;
    if (in_acc) begin
      ptr_nxt = ptr_r + 1'b1;
      if (&ptr_r) begin
        wrapped_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r     <= '0;
      wrapped_r <= 1'b0;
      s1_v_r    <= 1'b0;
    end else begin
      ptr_r     <= ptr_nxt;
      wrapped_r <= wrapped_nxt;
      s1_v_r    <= in_acc;
    end
  end

  // Stage 1 payload: square of the used sample bits
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_sq_r     <= SQ_W'(in_sample[SMP_USE_W-1:0]) * SQ_W'(in_sample[SMP_USE_W-1:0]);
      s1_ptr_r    <= ptr_r;
      s1_old_ok_r <= wrapped_r;
    end
  end

  // Entry not yet written since reset counts as a zero square
  assign old_sq = s1_old_ok_r ? ram_rd : '0;

  // ---------------------------------------------------------------
  // Running sum: add the new square, drop the oldest
  // ---------------------------------------------------------------
  always_comb begin
    sum_nxt = sum_r;
    if (s1_v_r) begin
      sum_nxt = sum_r - SUM_W'(old_sq) + SUM_W'(s1_sq_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      s2_v_r <= 1'b0;
    end else begin
      sum_r  <= sum_nxt;
      s2_v_r <= s1_v_r;
    end
  end

  // ---------------------------------------------------------------
  // Mean, saturation and thermometer bar
  // ---------------------------------------------------------------
  assign mean_x = MEAN_X_W'(sum_r >> WIN_LOG2);

  always_comb begin
    for (int k = 0; k < LEVELS; k++) begin
      exceed[k] = (mean_x > MEAN_X_W'(thr_r[k]));
    end
  end

  // Bar bit k lights when any level at or above k+1 is exceeded, so the
  // highest exceeded level fills the whole bar below it.
  always_comb begin
    res_nxt.bar = '0;
    for (int k = 0; k < LEVELS; k++) begin
      res_nxt.bar[k] = |(exceed >> k);
    end
    res_nxt.mean = (mean_x > MEAN_X_W'(MEAN_MAX)) ? MEAN_MAX : mean_x[MEAN_W-1:0];
  end

  // ---------------------------------------------------------------
  // Threshold registers; indexes past the last level are dropped
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LEVELS; k++) begin
        thr_r[k] <= THR_RESET[k];
      end
    end else if (cfg_we && (cfg_index < CFG_IDX_W'(LEVELS))) begin
      thr_r[cfg_index[LVL_AW-1:0]] <= cfg_data;
    end
  end

  // ---------------------------------------------------------------
  // Output queue; busy count keeps it from overflowing
  // ---------------------------------------------------------------
  always_comb begin
    oq_cnt_nxt = oq_cnt_r + OQ_CW'(s2_v_r) - OQ_CW'(out_acc);
    busy_nxt   = busy_r + OQ_CW'(in_acc) - OQ_CW'(out_acc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wp_r  <= '0;
      oq_rp_r  <= '0;
      oq_cnt_r <= '0;
      busy_r   <= '0;
    end else begin
      oq_cnt_r <= oq_cnt_nxt;
      busy_r   <= busy_nxt;
      if (s2_v_r) begin
        oq_wp_r <= oq_wp_r + 1'b1;
      end
      if (out_acc) begin
        oq_rp_r <= oq_rp_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_v_r) begin
      oq_r[oq_wp_r] <= res_nxt;
    end
  end

  assign out_bar_pattern = oq_r[oq_rp_r].bar;
  assign out_mean_power  = oq_r[oq_rp_r].mean;

endmodule

[hw/rtl/mpbm_ram.sv]
module mpbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[bench/mpbm_checker.sv]
module mpbm_checker
  import mpbm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [SAMPLE_W-1:0]  in_sample,

  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [BAR_W-1:0]     out_bar_pattern,
  input  logic [MEAN_W-1:0]    out_mean_power,

  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [THR_W-1:0]     cfg_data,

  output int                   fail_count,
  output int                   pending,
  output int                   checked,
  output logic [LEVELS:0]      levels_seen
);

  // shadow of the meter: squares in the window, their sum, next slot to replace
  logic [SQ_W-1:0]  square_hist [WINDOW];
  logic [SUM_W-1:0] energy_sum;
  int               oldest_slot;
  thr_t             level_thr [LEVELS];

  res_t readings_due [$];
  int   fails = 0;
  int   words_checked = 0;
  logic [LEVELS:0] bars_hit = '0;

  initial begin
    fail_count  = 0;
    pending     = 0;
    checked     = 0;
    levels_seen = '0;
  end

  task automatic predict_reading(input logic [SAMPLE_W-1:0] raw, output res_t reading);
    logic [SMP_USE_W-1:0] smp;
    logic [SQ_W-1:0]      sq;
    logic [MEAN_X_W-1:0]  mean_x;
    bit                   lit;
    smp        = raw[SMP_USE_W-1:0];
    sq         = SQ_W'(smp) * SQ_W'(smp);
    energy_sum = energy_sum - SUM_W'(square_hist[oldest_slot]) + SUM_W'(sq);
    mean_x     = MEAN_X_W'(energy_sum >> WIN_LOG2);
    // highest level strictly exceeded wins, even if lower ones are not
    reading.bar = '0;
    lit         = 1'b0;
    for (int k = LEVELS - 1; k >= 0; k--) begin
      if (!lit && mean_x > MEAN_X_W'(level_thr[k])) begin
        reading.bar = bar_t'((1 << (k + 1)) - 1);
        lit         = 1'b1;
      end
    end
    reading.mean = (mean_x > MEAN_X_W'(MEAN_MAX)) ? MEAN_MAX : mean_t'(mean_x);
    square_hist[oldest_slot] = sq;
    oldest_slot = (oldest_slot + 1) % WINDOW;
  endtask

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      foreach (square_hist[i]) square_hist[i] = '0;
      energy_sum  = '0;
      oldest_slot = 0;
      level_thr   = THR_RESET;
      readings_due.delete();
    end else begin
      if (cfg_we && cfg_index < LEVELS) level_thr[cfg_index[LVL_AW-1:0]] = cfg_data;

      if (in_valid && !in_stall) begin
        predict_reading(in_sample, want);
        readings_due.push_back(want);
      end

      if (out_valid && !out_stall) begin
        if (readings_due.size() == 0) begin
          $error("unexpected word: bar_pattern %h, mean_power %0d",
                 out_bar_pattern, out_mean_power);
          fails++;
        end else begin
          want = readings_due.pop_front();
          words_checked++;
          bars_hit[$countones(want.bar)] = 1'b1;
          if (out_bar_pattern !== want.bar) begin
            $error("bar_pattern: expected %h, got %h", want.bar, out_bar_pattern);
            fails++;
          end
          if (out_mean_power !== want.mean) begin
            $error("mean_power: expected %0d, got %0d", want.mean, out_mean_power);
            fails++;
          end
        end
      end
    end
    fail_count  <= fails;
    pending     <= readings_due.size();
    checked     <= words_checked;
    levels_seen <= bars_hit;
  end

endmodule

[bench/tb_top.sv]
module tb_top
  import mpbm_pkg::*;
();

  // cycles with no word moving on any port before the run is called hung
  localparam int STALL_LIMIT   = 2000;
  // receiver hold-off long enough to fill the output queue and back up the input
  localparam int HOLD_CYCLES   = 80;
  // quiet cycles after the last result before touching thresholds or finishing
  localparam int DRAIN_PAUSE   = 6;
  localparam int TARGET_WORDS  = 1600;

  // how a phase picks its eight thresholds
  typedef enum int {LV_ASCEND, LV_SHUFFLED, LV_DEFAULT, LV_EDGES} level_plan_t;
  // loudness of the samples in a phase
  typedef enum int {AMP_QUIET, AMP_MID, AMP_FULL, AMP_LOUD} amp_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  logic [SAMPLE_W-1:0]  in_sample = '0;

  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [BAR_W-1:0]     out_bar_pattern;
  logic [MEAN_W-1:0]    out_mean_power;

  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  thr_t                 cfg_data  = '0;

  int              fail_count;
  int              pending;
  int              checked;
  logic [LEVELS:0] levels_seen;

  // calm: neither side idles; hold_asks: bumped to make the receiver hold off
  bit calm      = 1'b0;
  int hold_asks = 0;
  int words_sent = 0;
  int settings   = 0;

  always #10 clk = ~clk;

  moving_power_bar_meter_unit u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample       (in_sample),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_bar_pattern (out_bar_pattern),
    .out_mean_power  (out_mean_power),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  mpbm_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample       (in_sample),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_bar_pattern (out_bar_pattern),
    .out_mean_power  (out_mean_power),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .pending         (pending),
    .checked         (checked),
    .levels_seen     (levels_seen)
  );

  // Half the words go straight through, the rest are held back first; with calm set, none are.
  function automatic int draw_gap();
    if (calm || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(1, 18);
  endfunction

  // Offer one sample and wait for it to be taken. Valid stays high afterwards
  // so the next word can follow back to back.
  task automatic send_sample(input logic [SAMPLE_W-1:0] smp);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= smp;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  // Drop valid, wait for every predicted result to come back, then let the
  // pipeline sit quiet before the next register write.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  // Write all eight thresholds back to back; optionally also hit the unused
  // indexes with junk, which the block must ignore.
  task automatic program_levels(input thr_t lv [LEVELS], input bit also_unused);
    if (also_unused) begin
      for (int idx = LEVELS; idx < (1 << CFG_IDX_W); idx++) begin
        cfg_we    <= 1'b1;
        cfg_index <= CFG_IDX_W'(idx);
        cfg_data  <= thr_t'($urandom);
        @(posedge clk);
      end
    end
    for (int k = 0; k < LEVELS; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(k);
      cfg_data  <= lv[k];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    settings++;
  endtask

  task automatic pick_levels(input level_plan_t plan, input int unsigned spread,
                             output thr_t lv [LEVELS]);
    int unsigned pool [$];
    repeat (LEVELS) pool.push_back($urandom_range(0, spread));
    if (plan == LV_ASCEND) pool.sort();
    for (int k = 0; k < LEVELS; k++) begin
      case (plan)
        LV_DEFAULT: lv[k] = THR_RESET[k];
        LV_EDGES:   lv[k] = $urandom_range(0, 1) ? MEAN_MAX : thr_t'(0);
        default:    lv[k] = thr_t'(pool[k]);
      endcase
    end
  endtask

  // Receiver: stall at random before each word, or on request hold off long
  // enough that the block fills and stalls its input.
  initial begin
    int holds_done;
    int n;
    holds_done = 0;
    forever begin
      if (hold_asks != holds_done) begin
        holds_done++;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        n = draw_gap();
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Watchdog: any accepted word on any port restarts the count.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("no word moved for %0d cycles, %0d results outstanding", STALL_LIMIT, pending);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    thr_t        lv [LEVELS];
    logic [SAMPLE_W-1:0] first_run [$];
    int          phase_no;
    int          n;
    int unsigned lo;
    int unsigned hi;
    int          r;
    level_plan_t plan;
    amp_t        amp;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Tiny ascending thresholds 0..7 so single samples land exactly on them.
    // 32*32 = 1024 gives mean 1: above level1 (0) but equal to level2 (1).
    // 64 pushes the mean to 7, equal to level8, so only seven bits light.
    for (int k = 0; k < LEVELS; k++) lv[k] = thr_t'(k);
    program_levels(lv, 1'b1);
    first_run = '{12'd0, 12'd32, 12'd32, 12'd45, 12'd64, 12'd1, 12'd2, 12'd4,
                  12'd8, 12'd16, 12'd4095, 12'd2048, 12'd1024, 12'd512,
                  12'd256, 12'd128, 12'hAAA, 12'h555};
    foreach (first_run[i]) send_sample(first_run[i]);
    drain();

    // Out of order: only level8 reachable, it alone must light the full bar.
    foreach (lv[k]) lv[k] = MEAN_MAX;
    lv[LEVELS-1] = '0;
    program_levels(lv, 1'b0);
    send_sample(12'd0);
    send_sample(12'd100);
    send_sample(12'd4095);
    drain();

    // Nothing reachable: dark bar whatever the mean.
    foreach (lv[k]) lv[k] = MEAN_MAX;
    program_levels(lv, 1'b0);
    send_sample(12'd4095);
    send_sample(12'd3);
    drain();

    // Everything at zero: any nonzero mean lights all eight.
    foreach (lv[k]) lv[k] = '0;
    program_levels(lv, 1'b0);
    send_sample(12'd0);
    send_sample(12'd7);
    drain();

    // Random phases: a loudness, a threshold set spread around the mean that
    // loudness tends toward, then a burst of samples. The running window
    // carries across phases, so the mean sweeps through the levels.
    phase_no = 0;
    while (words_sent < TARGET_WORDS) begin
      phase_no++;
      calm = (phase_no % 4 == 0) || phase_no == 3 || phase_no == 9;
      amp  = amp_t'($urandom_range(0, 3));
      case (amp)
        AMP_QUIET: begin lo = 0;    hi = $urandom_range(1, 255);    end
        AMP_MID:   begin lo = 0;    hi = $urandom_range(256, 2047); end
        AMP_LOUD:  begin lo = 3072; hi = 4095;                      end
        default:   begin lo = 0;    hi = 4095;                      end
      endcase
      r = $urandom_range(0, 9);
      if (r < 6)       plan = LV_ASCEND;
      else if (r < 8)  plan = LV_SHUFFLED;
      else if (r == 8) plan = LV_DEFAULT;
      else             plan = LV_EDGES;
      pick_levels(plan, hi * hi / 2 + 8, lv);
      program_levels(lv, phase_no % 3 == 0);

      // back-pressure phases: sender streams without gaps into a held output
      if (phase_no == 3 || phase_no == 9) hold_asks <= hold_asks + 1;

      n = $urandom_range(80, 240);
      repeat (n) begin
        if ($urandom_range(0, 31) == 0)
          send_sample(SAMPLE_W'($urandom_range(0, 4095)));
        else
          send_sample(SAMPLE_W'($urandom_range(lo, hi)));
      end
      drain();
    end

    $display("Sent %0d samples under %0d threshold settings, %0d results compared.",
             words_sent, settings, checked);
    $display("Bar levels reached (bit n = n bars lit): %b", levels_seen);
    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/mpbm_pkg.sv
hw/rtl/mpbm_ram.sv
hw/rtl/moving_power_bar_meter_unit.sv
bench/mpbm_checker.sv
bench/tb_top.sv
